@@ rtl/blr_pkg.sv @@
// Shared types and constants of the line rasterizer.
// Depends on nothing; imported by the interfaces and by every module but blr_queue.
package blr_pkg;

   localparam int FIELD_W     = 16;  // coordinate and color field width on the channels
   localparam int CFG_W       = 12;  // width of each control register
   localparam int CSR_INDEX_W = 2;

   localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;
   localparam logic [CFG_W-1:0] ROW_PITCH_RESET     = 12'd640;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_ROW_PITCH     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] screen_width;
      logic [CFG_W-1:0] screen_height;
      logic [CFG_W-1:0] row_pitch_words;
   } cfg_type;

endpackage

@@ rtl/blr_req_if.sv @@
// Command channel of the line rasterizer: valid/ready plus the command fields.
// Depends on blr_pkg.
interface blr_req_if
   import blr_pkg::*;
   ();

   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [FIELD_W-1:0] start_x;
   logic signed [FIELD_W-1:0] start_y;
   logic signed [FIELD_W-1:0] end_x;
   logic signed [FIELD_W-1:0] end_y;
   logic        [FIELD_W-1:0] line_color;

   modport source (
      output valid, opcode, start_x, start_y, end_x, end_y, line_color,
      input  ready
   );

   modport sink (
      input  valid, opcode, start_x, start_y, end_x, end_y, line_color,
      output ready
   );

endinterface

@@ rtl/blr_rsp_if.sv @@
// Point channel of the line rasterizer: valid/ready plus one rasterized point.
// Depends on blr_pkg.
interface blr_rsp_if
   import blr_pkg::*;
   #(parameter int ADDR_BITS = 22)
   ();

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] point_x;
   logic signed [FIELD_W-1:0] point_y;
   logic [ADDR_BITS-1:0]      pixel_address;
   logic [FIELD_W-1:0]        pixel_color;
   logic                      on_screen;
   logic                      last_point;

   modport source (
      output valid, point_x, point_y, pixel_address, pixel_color, on_screen, last_point,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, pixel_address, pixel_color, on_screen, last_point,
      output ready
   );

endinterface

@@ rtl/blr_queue.sv @@
// Two-entry command queue between the setup front and the stepping back end.
// Generic over the entry type; depends on nothing else.
module blr_queue #(
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head_data,
   output logic      full,
   output logic      empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic [PTR_W-1:0] tail;

   assign tail      = head_ff + count_ff[PTR_W-1:0];
   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop && !empty) begin
         head_in = head_ff + 1'b1;
      end
      if (push && !full && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[tail] <= push_data;
      end
   end

endmodule

@@ rtl/blr_front.sv @@
// Front end: takes command beats, classifies them and does the line setup
// (deltas, step directions, initial error). Depends on blr_pkg and blr_req_if.
module blr_front
   import blr_pkg::*;
   #(
   parameter int  COORD_BITS = 16,
   parameter type cmd_type   = logic
) (
   blr_req_if.sink req_bus,
   input  logic    queue_full,
   output logic    push,
   output cmd_type push_cmd
);

   localparam int CB = COORD_BITS;

   logic signed [CB-1:0] x0, y0, x1, y1;
   logic signed [CB:0]   diff_x, diff_y;
   logic        [CB:0]   dx, dy;

   // only the low COORD_BITS of each endpoint count, sign-extended
   assign x0 = req_bus.start_x[CB-1:0];
   assign y0 = req_bus.start_y[CB-1:0];
   assign x1 = req_bus.end_x[CB-1:0];
   assign y1 = req_bus.end_y[CB-1:0];

   assign diff_x = (CB+1)'(x1) - (CB+1)'(x0);
   assign diff_y = (CB+1)'(y1) - (CB+1)'(y0);
   assign dx     = diff_x[CB] ? ((CB+1)'(0) - diff_x) : diff_x;
   assign dy     = diff_y[CB] ? ((CB+1)'(0) - diff_y) : diff_y;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      push_cmd.opcode = opcode_type'(req_bus.opcode);
      push_cmd.x0     = x0;
      push_cmd.y0     = y0;
      push_cmd.x1     = x1;
      push_cmd.y1     = y1;
      push_cmd.dx     = dx;
      push_cmd.dy     = dy;
      // step negative unless the end lies strictly ahead
      push_cmd.sxn    = diff_x[CB] || (diff_x == '0);
      push_cmd.syn    = diff_y[CB] || (diff_y == '0);
      push_cmd.err    = signed'((CB+2)'(dx)) - signed'((CB+2)'(dy));
      push_cmd.color  = req_bus.line_color;
   end

endmodule

@@ rtl/blr_back.sv @@
// Back end: Bresenham stepper, clipping and framebuffer address pipeline,
// output register. Depends on blr_pkg and blr_rsp_if.
module blr_back
   import blr_pkg::*;
   #(
   parameter int  COORD_BITS = 16,
   parameter int  ADDR_BITS  = 22,
   parameter type cmd_type   = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   blr_rsp_if.source   rsp_bus
);

   localparam int CB     = COORD_BITS;
   localparam int CMP_W  = (CB > CFG_W) ? CB : CFG_W;
   localparam int PROD_W = 2 * CFG_W;
   localparam int SUM_W  = (ADDR_BITS > PROD_W + 1) ? ADDR_BITS : PROD_W + 1;

   logic adv;

   // ---------------- stepper state ----------------
   logic signed [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CB-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic        [CB:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic                 sxn_ff, sxn_in, syn_ff, syn_in;
   logic signed [CB+1:0] err_ff, err_in;
   logic [FIELD_W-1:0]   color_ff, color_in;
   logic                 active_ff, active_in;

   logic signed [CB+2:0] e2, dx_e, dy_e, err_step;
   logic                 move_x, move_y;
   logic signed [CB-1:0] x_step, y_step;
   logic                 produce, last;

   // stage 1: point, stage 2: clip and multiply, stage 3: output
   logic                 s1_valid_ff, s1_last_ff;
   logic signed [CB-1:0] s1_x_ff, s1_y_ff;
   logic [FIELD_W-1:0]   s1_color_ff;

   logic                 s2_valid_ff, s2_last_ff, s2_vis_ff;
   logic signed [FIELD_W-1:0] s2_x_ff, s2_y_ff;
   logic [FIELD_W-1:0]   s2_color_ff;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic [CFG_W-1:0]     s2_x12_ff;

   logic                 s3_valid_ff, s3_last_ff, s3_vis_ff;
   logic signed [FIELD_W-1:0] s3_x_ff, s3_y_ff;
   logic [FIELD_W-1:0]   s3_color_ff;
   logic [ADDR_BITS-1:0] s3_addr_ff;

   logic [CMP_W-1:0]     ux, uy;
   logic                 vis;
   logic [SUM_W-1:0]     addr_sum;

   // whole back end stalls together on the output register
   assign adv     = !s3_valid_ff || rsp_bus.ready;
   assign cmd_pop = adv && cmd_valid;

   assign e2       = {err_ff, 1'b0};
   assign dx_e     = signed'((CB+3)'(dx_ff));
   assign dy_e     = signed'((CB+3)'(dy_ff));
   assign move_x   = e2 > -dy_e;
   assign move_y   = e2 < dx_e;
   assign err_step = (CB+3)'(err_ff) - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
   assign x_step   = move_x ? (sxn_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1)) : cur_x_ff;
   assign y_step   = move_y ? (syn_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1)) : cur_y_ff;

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sxn_in    = sxn_ff;
      syn_in    = syn_ff;
      err_in    = err_ff;
      color_in  = color_ff;
      produce   = 1'b0;
      priority if (cmd_pop && cmd.opcode == OP_START) begin
         cur_x_in = cmd.x0;
         cur_y_in = cmd.y0;
         tgt_x_in = cmd.x1;
         tgt_y_in = cmd.y1;
         dx_in    = cmd.dx;
         dy_in    = cmd.dy;
         sxn_in   = cmd.sxn;
         syn_in   = cmd.syn;
         err_in   = cmd.err;
         color_in = cmd.color;
         produce  = 1'b1;
      end else if (cmd_pop && active_ff) begin
         cur_x_in = x_step;
         cur_y_in = y_step;
         err_in   = err_step[CB+1:0];
         produce  = 1'b1;
      end else begin
         produce  = 1'b0;  // idle step or no beat: bubble
      end
      last      = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      active_in = produce ? !last : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sxn_ff   <= sxn_in;
      syn_ff   <= syn_in;
      err_ff   <= err_in;
      color_ff <= color_in;
   end

   // clipping: a visible point has both coordinates non-negative and below the screen width and height
   assign ux  = CMP_W'(s1_x_ff[CB-1:0]);
   assign uy  = CMP_W'(s1_y_ff[CB-1:0]);
   assign vis = !s1_x_ff[CB-1] && (ux < CMP_W'(cfg.screen_width)) &&
                !s1_y_ff[CB-1] && (uy < CMP_W'(cfg.screen_height));

   assign addr_sum = SUM_W'(s2_prod_ff) + SUM_W'(s2_x12_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= produce;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff     <= cur_x_in;
         s1_y_ff     <= cur_y_in;
         s1_last_ff  <= last;
         s1_color_ff <= color_in;

         s2_x_ff     <= FIELD_W'(s1_x_ff);
         s2_y_ff     <= FIELD_W'(s1_y_ff);
         s2_last_ff  <= s1_last_ff;
         s2_color_ff <= s1_color_ff;
         s2_vis_ff   <= vis;
         s2_prod_ff  <= uy[CFG_W-1:0] * cfg.row_pitch_words;
         s2_x12_ff   <= ux[CFG_W-1:0];

         s3_x_ff     <= s2_x_ff;
         s3_y_ff     <= s2_y_ff;
         s3_last_ff  <= s2_last_ff;
         s3_color_ff <= s2_color_ff;
         s3_vis_ff   <= s2_vis_ff;
         s3_addr_ff  <= s2_vis_ff ? addr_sum[ADDR_BITS-1:0] : '0;
      end
   end

   assign rsp_bus.valid         = s3_valid_ff;
   assign rsp_bus.point_x       = s3_x_ff;
   assign rsp_bus.point_y       = s3_y_ff;
   assign rsp_bus.pixel_address = s3_addr_ff;
   assign rsp_bus.pixel_color   = s3_color_ff;
   assign rsp_bus.on_screen     = s3_vis_ff;
   assign rsp_bus.last_point    = s3_last_ff;

endmodule

@@ rtl/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer: control registers, setup front,
// command queue and stepping back end. Depends on blr_pkg, the interfaces and all blr_ modules.
//
//   port        dir   kind         carries
//   req_bus     in    valid/ready  start or step command, endpoints, color
//   rsp_bus     out   valid/ready  point x/y, word address, color, on-screen, last
//   csr_*       in    write only   screen width, screen height, row pitch
//
// One beat per cycle sustained in both directions while rsp_bus is ready; the stepper's
// add, compare and select loop is combinational. A point passes through the queue,
// stepper, clip/multiply stage and output register. Reset is synchronous and
// returns the registers to 640x480, pitch 640, with no line active. A stall on rsp_bus
// freezes the back end; the two-entry queue keeps req_bus ready while it has room.
module bresenham_line_rasterizer
   import blr_pkg::*;
   #(
   parameter int COORD_BITS = 16,
   parameter int ADDR_BITS  = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   blr_req_if.sink                req_bus,
   blr_rsp_if.source              rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   typedef struct packed {
      opcode_type                opcode;
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic        [COORD_BITS:0]   dx;
      logic        [COORD_BITS:0]   dy;
      logic                         sxn;
      logic                         syn;
      logic signed [COORD_BITS+1:0] err;
      logic        [FIELD_W-1:0]    color;
   } cmd_type;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, head_cmd;
   logic    push, pop, queue_full, queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  cfg_in.screen_width    = csr_write_data;
            CSR_SCREEN_HEIGHT: cfg_in.screen_height   = csr_write_data;
            CSR_ROW_PITCH:     cfg_in.row_pitch_words = csr_write_data;
            default:           cfg_in = cfg_ff;  // unmapped index is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width    <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height   <= SCREEN_HEIGHT_RESET;
         cfg_ff.row_pitch_words <= ROW_PITCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   blr_front #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   blr_queue #(
      .entry_type (cmd_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head_data (head_cmd),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   blr_back #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS),
      .cmd_type   (cmd_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!queue_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
